@@ rtl/jcs_pkg.sv @@
package jcs_pkg;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;

	localparam logic [1:0] MODE_NONE  = 2'd0;
	localparam logic [1:0] MODE_LINE  = 2'd1;
	localparam logic [1:0] MODE_BLOCK = 2'd2;

	// Default depth of the result queue; it must hold at least two words.
	localparam int QUEUE_DEPTH = 4;

	// Scanner state that travels from one decided byte to the next.
	typedef struct packed {
		logic [1:0] mode;
		logic       in_str;
		logic       skip;
		logic [7:0] prev;
		logic [7:0] pprev;
	} scan_t;

	typedef struct packed {
		scan_t st;
		logic  keep;
	} decision_t;

	typedef struct packed {
		logic [7:0] data;
		logic       keep;
		logic       last;
	} result_t;

	// Decides byte b, given the byte nx that follows it.
	function automatic decision_t jcs_decide(scan_t s, logic [7:0] b, logic [7:0] nx);
		decision_t r;
		logic      esc;
		r      = '{st: s, keep: 1'b0};
		esc    = (s.prev == CH_BSLASH) && (s.pprev != CH_BSLASH);
		if (s.skip) begin
			r.st.skip = 1'b0;
			r.keep    = (b == CH_LF);
		end else begin
			if (s.mode == MODE_NONE && b == CH_QUOTE && !esc) begin
				r.st.in_str = !s.in_str;
			end
			if (r.st.in_str) begin
				r.keep = 1'b1;
			end else if (s.mode == MODE_NONE && b == CH_SLASH && nx == CH_SLASH) begin
				r.st.mode = MODE_LINE;
				r.st.skip = 1'b1;
			end else if (s.mode == MODE_LINE && b == CH_CR && nx == CH_LF) begin
				r.st.mode = MODE_NONE;
				r.st.skip = 1'b1;
				r.keep    = 1'b1;
			end else if (s.mode == MODE_LINE && b == CH_LF) begin
				r.st.mode = MODE_NONE;
				r.keep    = 1'b1;
			end else if (s.mode == MODE_NONE && b == CH_SLASH && nx == CH_STAR) begin
				r.st.mode = MODE_BLOCK;
				r.st.skip = 1'b1;
			end else if (s.mode == MODE_BLOCK && b == CH_STAR && nx == CH_SLASH) begin
				r.st.mode = MODE_NONE;
				r.st.skip = 1'b1;
			end else begin
				r.keep = (s.mode == MODE_NONE);
			end
		end
		r.st.pprev = s.prev;
		r.st.prev  = b;
		return r;
	endfunction

endpackage

@@ rtl/json_comment_stripper.sv @@
// JSON comment stripper. Bytes of a JSON text enter one word per clock on the
// input channel; every byte outside // line comments and /* */ block comments
// leaves on the output channel, and comment bytes, including both bytes of
// each opener and of the closing star-slash, are dropped. The LF or CRLF that
// ends a line comment is kept, a lone CR inside a line comment is dropped,
// and nothing inside a double-quoted string counts as a comment opener. A
// quote is escaped when the byte before it is a backslash and the byte before
// that is not. Each byte is held back one word as lookahead, so a byte leaves
// once the next one has arrived; the word flagged with in_last is decided at
// once against a lookahead of zero, and the final output word of the
// document carries out_last. If the document ends with nothing to send, an
// empty end marker (out_keep low, out_byte zero, out_last high) is sent, so a
// document end is always visible. After a last word the block starts a new
// document. The block takes one input word per clock while in_ready is high:
// the whole decision is combinational, and its results enter a small queue
// (QDEPTH words) that parts the two channels. in_ready is high while the
// queue has room for the two words that one input word can produce at most.
// With the output side taking one word per clock the queue never holds more
// than two words, so with QDEPTH of four or more the input never stalls;
// only a receiver that holds off fills the queue and drops in_ready.
module json_comment_stripper #(
	parameter int QDEPTH = jcs_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_keep,
	output logic       out_last
);
	import jcs_pkg::*;

	localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CW = $clog2(QDEPTH + 1);
	localparam logic [PW-1:0] PTR_MAX = PW'(QDEPTH - 1);

	// Scanner state and the lookahead byte.
	scan_t      scan_q;
	logic [7:0] held_q;
	logic       held_valid_q;

	// Result queue.
	result_t       queue_q [QDEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	logic          in_fire;
	logic          out_fire;
	decision_t     dec_held;
	decision_t     dec_last;
	scan_t         scan_mid;
	logic          keep_held;
	logic          keep_last;
	result_t       res0;
	result_t       res1;
	logic [1:0]    n_push;
	logic [PW-1:0] wr_ptr_inc;
	logic [PW-1:0] rd_ptr_inc;

	assign in_ready  = (count_q <= CW'(QDEPTH - 2));
	assign in_fire   = in_valid && in_ready;
	assign out_valid = (count_q != '0);
	assign out_fire  = out_valid && out_ready;

	assign out_byte = queue_q[rd_ptr_q].data;
	assign out_keep = queue_q[rd_ptr_q].keep;
	assign out_last = queue_q[rd_ptr_q].last;

	// The held byte is decided now that its lookahead has arrived; on a last
	// word the new byte is decided as well, against a zero lookahead.
	assign dec_held  = jcs_decide(scan_q, held_q, in_byte);
	assign keep_held = held_valid_q && dec_held.keep;
	assign scan_mid  = held_valid_q ? dec_held.st : scan_q;
	assign dec_last  = jcs_decide(scan_mid, in_byte, 8'h00);
	assign keep_last = in_last && dec_last.keep;

	// Pack up to two results; the final one of a document gets its last flag,
	// and an empty end marker stands in when nothing is kept.
	always_comb begin
		res0   = '{data: held_q, keep: 1'b1, last: 1'b0};
		res1   = '{data: in_byte, keep: 1'b1, last: in_last};
		n_push = 2'd0;
		if (keep_held && keep_last) begin
			n_push = 2'd2;
		end else if (keep_held) begin
			n_push    = 2'd1;
			res0.last = in_last;
		end else if (keep_last) begin
			n_push = 2'd1;
			res0   = '{data: in_byte, keep: 1'b1, last: 1'b1};
		end else if (in_last) begin
			n_push = 2'd1;
			res0   = '{data: 8'h00, keep: 1'b0, last: 1'b1};
		end
		if (!in_fire) begin
			n_push = 2'd0;
		end
	end

	assign wr_ptr_inc = (wr_ptr_q == PTR_MAX) ? '0 : wr_ptr_q + PW'(1);
	assign rd_ptr_inc = (rd_ptr_q == PTR_MAX) ? '0 : rd_ptr_q + PW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q       <= '0;
			held_valid_q <= 1'b0;
		end else if (in_fire) begin
			if (in_last) begin
				scan_q       <= '0;
				held_valid_q <= 1'b0;
			end else begin
				scan_q       <= scan_mid;
				held_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			held_q <= in_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (n_push != 2'd0) begin
			queue_q[wr_ptr_q] <= res0;
		end
		if (n_push == 2'd2) begin
			queue_q[wr_ptr_inc] <= res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (n_push == 2'd1) begin
				wr_ptr_q <= wr_ptr_inc;
			end else if (n_push == 2'd2) begin
				wr_ptr_q <= (wr_ptr_inc == PTR_MAX) ? '0 : wr_ptr_inc + PW'(1);
			end
			if (out_fire) begin
				rd_ptr_q <= rd_ptr_inc;
			end
			count_q <= count_q + CW'(n_push) - CW'(out_fire);
		end
	end

`ifndef SYNTHESIS
	// The queue never holds more words than it has entries.
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(QDEPTH))
		else $error("result queue overflow");

	// An empty word is only ever the end marker of a document.
	a_marker_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_keep) |-> out_last)
		else $error("empty word without last flag");

	// After the last word of a document nothing is held back.
	a_last_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && in_last) |=> (!held_valid_q && scan_q == '0))
		else $error("state not cleared after document end");
`endif

endmodule

@@ tb/json_comment_stripper_test.sv @@
`timescale 1ns / 1ps

module json_comment_stripper_test;
	import jcs_pkg::*;

	// One raw word on the way in and one stripped word on the way out.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} raw_word_t;

	typedef struct packed {
		logic [7:0] data;
		logic       keep;
		logic       last;
	} kept_word_t;

	localparam int RANDOM_WORDS = 1150;
	// The last stretch of the run goes without any idling on either side.
	localparam int CALM_WORDS   = 150;
	localparam int HOLD_AFTER   = 300;
	localparam int HOLD_CYCLES  = 250;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT  = 200000;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	logic [7:0] in_byte   = 8'h00;
	logic       in_last   = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] out_byte;
	logic       out_keep;
	logic       out_last;

	// Stimulus still to be offered, and the stripped words still owed by the block.
	raw_word_t  doc_words[$];
	kept_word_t kept_due[$];
	logic [7:0] doc_bytes[$];

	// Copy of the scanner that the block is expected to run.
	logic [1:0] scan_mode   = MODE_NONE;
	logic       scan_in_str = 1'b0;
	logic       scan_skip   = 1'b0;
	logic [7:0] scan_prev   = 8'h00;
	logic [7:0] scan_pprev  = 8'h00;
	logic [7:0] look_byte   = 8'h00;
	logic       look_ok     = 1'b0;

	int   mismatches = 0;
	int   words_in   = 0;
	int   gap_left   = 0;
	int   stall_left = 0;
	int   hold_left  = 0;
	logic hold_done  = 1'b0;
	logic calm       = 1'b0;
	int   cycles     = 0;

	string plain_chars = "{}[]:,.-+0123456789aeflnrstu \t";

	json_comment_stripper DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte (out_byte),
		.out_keep (out_keep),
		.out_last (out_last)
	);

	always #4 clk = ~clk;

	// Every document starts from a clean scanner, with the bytes before it
	// taken as zero.
	task automatic clear_scanner();
		scan_mode   = MODE_NONE;
		scan_in_str = 1'b0;
		scan_skip   = 1'b0;
		scan_prev   = 8'h00;
		scan_pprev  = 8'h00;
		look_byte   = 8'h00;
		look_ok     = 1'b0;
	endtask

	// Decides whether byte b survives, given the byte nx that follows it.
	function automatic bit byte_survives(input logic [7:0] b, input logic [7:0] nx);
		bit kept;
		bit escaped;
		kept    = 1'b0;
		escaped = (scan_prev == CH_BSLASH) && (scan_pprev != CH_BSLASH);
		if (scan_skip) begin
			// Second byte of a two-byte token: only the LF of a CRLF survives.
			scan_skip = 1'b0;
			kept      = (b == CH_LF);
		end else begin
			if (scan_mode == MODE_NONE && b == CH_QUOTE && !escaped)
				scan_in_str = !scan_in_str;
			if (scan_in_str) begin
				kept = 1'b1;
			end else if (scan_mode == MODE_NONE && b == CH_SLASH && nx == CH_SLASH) begin
				scan_mode = MODE_LINE;
				scan_skip = 1'b1;
			end else if (scan_mode == MODE_LINE && b == CH_CR && nx == CH_LF) begin
				scan_mode = MODE_NONE;
				scan_skip = 1'b1;
				kept      = 1'b1;
			end else if (scan_mode == MODE_LINE && b == CH_LF) begin
				scan_mode = MODE_NONE;
				kept      = 1'b1;
			end else if (scan_mode == MODE_NONE && b == CH_SLASH && nx == CH_STAR) begin
				scan_mode = MODE_BLOCK;
				scan_skip = 1'b1;
			end else if (scan_mode == MODE_BLOCK && b == CH_STAR && nx == CH_SLASH) begin
				scan_mode = MODE_NONE;
				scan_skip = 1'b1;
			end else begin
				kept = (scan_mode == MODE_NONE);
			end
		end
		scan_pprev = scan_prev;
		scan_prev  = b;
		return kept;
	endfunction

	// Works out the stripped words that one accepted input word releases.
	// The held byte is decided now that its lookahead is known; a final byte
	// is decided at once against a zero lookahead.
	task automatic strip_word(input logic [7:0] b, input logic fin);
		kept_word_t got[$];
		if (look_ok && byte_survives(look_byte, b))
			got.insert(got.size(), kept_word_t'{data: look_byte, keep: 1'b1, last: 1'b0});
		look_byte = b;
		look_ok   = 1'b1;
		if (fin) begin
			if (byte_survives(b, 8'h00))
				got.insert(got.size(), kept_word_t'{data: b, keep: 1'b1, last: 1'b0});
			// A document that ends with nothing kept still gets an end marker.
			if (got.size() == 0)
				got.insert(0, kept_word_t'{data: 8'h00, keep: 1'b0, last: 1'b1});
			else
				got[got.size() - 1].last = 1'b1;
			clear_scanner();
		end
		foreach (got[i])
			kept_due.insert(kept_due.size(), got[i]);
	endtask

	task automatic check_word(input logic [7:0] d, input logic k, input logic l);
		kept_word_t want;
		if (kept_due.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected word: byte %h keep %b last %b", d, k, l);
		end else begin
			want = kept_due.pop_front();
			if (want.data !== d || want.keep !== k || want.last !== l) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"mismatch: expected byte %h keep %b last %b, ",
						"got byte %h keep %b last %b"},
						want.data, want.keep, want.last, d, k, l);
			end
		end
	endtask

	// Appends one byte to the document being built.
	task automatic add_byte(input logic [7:0] b);
		doc_bytes.insert(doc_bytes.size(), b);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endtask

	// Closes the document being built: its final byte carries the last flag.
	task automatic end_doc();
		for (int i = 0; i < doc_bytes.size(); i++)
			doc_words.insert(doc_words.size(),
				raw_word_t'{data: doc_bytes[i], last: (i == doc_bytes.size() - 1)});
		doc_bytes.delete();
	endtask

	function automatic logic [7:0] plain_byte();
		return plain_chars[$urandom_range(0, plain_chars.len() - 1)];
	endfunction

	// Bytes that matter to the scanner, mixed with the odd arbitrary one.
	function automatic logic [7:0] tricky_byte();
		case ($urandom_range(0, 7))
			0: return CH_QUOTE;
			1: return CH_BSLASH;
			2: return CH_SLASH;
			3: return CH_STAR;
			4: return CH_LF;
			5: return CH_CR;
			6: return 8'($urandom_range(0, 255));
			default: return plain_byte();
		endcase
	endfunction

	// A random document built mostly from well-formed pieces: plain text,
	// strings with escapes, line comments ended by LF or CRLF and block
	// comments, with some stray bytes thrown in.
	task automatic add_random_doc();
		int pieces;
		int n;
		pieces = $urandom_range(1, 6);
		repeat (pieces) begin
			case ($urandom_range(0, 9))
				0, 1: begin
					n = $urandom_range(1, 6);
					repeat (n) add_byte(plain_byte());
				end
				2, 3: begin
					add_byte(CH_QUOTE);
					n = $urandom_range(0, 6);
					repeat (n) begin
						if ($urandom_range(0, 3) == 0) begin
							add_byte(CH_BSLASH);
							add_byte(tricky_byte());
						end else if ($urandom_range(0, 1) == 0) begin
							add_byte(tricky_byte());
						end else begin
							add_byte(plain_byte());
						end
					end
					add_byte(CH_QUOTE);
				end
				4, 5: begin
					push_text("//");
					n = $urandom_range(0, 6);
					repeat (n) add_byte($urandom_range(0, 1) ? tricky_byte() : plain_byte());
					if ($urandom_range(0, 1) == 0)
						add_byte(CH_CR);
					add_byte(CH_LF);
				end
				6, 7: begin
					push_text("/*");
					n = $urandom_range(0, 6);
					repeat (n) add_byte($urandom_range(0, 1) ? tricky_byte() : plain_byte());
					push_text("*/");
				end
				8: add_byte(8'($urandom_range(0, 255)));
				default: add_byte(tricky_byte());
			endcase
		end
		end_doc();
	endtask

	// Driver: offers the next pending word whenever the channel is free,
	// with random gaps after some words until the calm stretch at the end.
	always @(posedge clk or negedge arst_n) begin
		raw_word_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_byte  <= 8'h00;
			in_last  <= 1'b0;
			gap_left <= 0;
			calm     <= 1'b0;
		end else begin
			calm <= (doc_words.size() < CALM_WORDS);
			if (!in_valid || in_ready) begin
				if (gap_left != 0) begin
					in_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (doc_words.size() != 0) begin
					nxt = doc_words.pop_front();
					in_valid <= 1'b1;
					in_byte  <= nxt.data;
					in_last  <= nxt.last;
					if (!calm && $urandom_range(0, 7) == 0)
						gap_left <= $urandom_range(1, 11);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: predicts from every accepted input word and checks every
	// accepted output word at the same edge, then picks the next out_ready.
	// Once, after a few hundred input words, the receiver holds off for a
	// long stretch so that the result queue fills and in_ready drops.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready  <= 1'b0;
			stall_left <= 0;
			hold_left  <= 0;
			hold_done  <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				strip_word(in_byte, in_last);
				words_in++;
			end
			if (out_valid && out_ready)
				check_word(out_byte, out_keep, out_last);

			if (hold_left != 0) begin
				out_ready <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (!hold_done && words_in >= HOLD_AFTER) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_CYCLES - 1;
				out_ready <= 1'b0;
			end else if (stall_left != 0) begin
				out_ready  <= 1'b0;
				stall_left <= stall_left - 1;
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				out_ready  <= 1'b0;
				stall_left <= $urandom_range(1, 11) - 1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog against a block that stops moving.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		// Directed documents first. A block comment at the very start whose
		// closing star-slash ends the document, so only an end marker is left.
		push_text("/**/");
		end_doc();
		// A lone CR inside a line comment, then a CRLF that ends it.
		push_text("//");
		add_byte(CH_CR);
		add_byte(CH_CR);
		add_byte(CH_LF);
		push_text("x");
		end_doc();
		// A leading backslash escapes the quote right after it, so the
		// slashes open an unterminated line comment.
		push_text("\\\"//");
		end_doc();
		// A doubled backslash does not escape the quote that follows it,
		// and the block comment after it is never closed.
		push_text("\"\\\\\"/*");
		end_doc();
		// Byte extremes, then a one-byte document decided with no held byte.
		add_byte(8'h00);
		add_byte(8'hFF);
		end_doc();
		add_byte(CH_SLASH);
		end_doc();
		// An unterminated string hides the comment opener inside it.
		push_text("\"/*");
		end_doc();

		while (doc_words.size() < RANDOM_WORDS)
			add_random_doc();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (doc_words.size() != 0 || in_valid)
			@(posedge clk);
		while (kept_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
